// ===== rtl/mbps_pkg.sv =====
package mbps_pkg;

    // default window depth, handed to the top level parameter
    localparam int MAX_PATTERN_BYTES_DEF = 16;

    // fixed register file layout
    localparam int PAT_BYTES  = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 8;
    localparam int LEN_CFG_W  = 5;
    localparam int OFFSET_W   = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 8'd0,
        CFG_PATTERN_HIGH = 8'd1,
        CFG_CARE_MASK    = 8'd2,
        CFG_PATTERN_LEN  = 8'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [8*PAT_BYTES-1:0] pattern;
        logic [PAT_BYTES-1:0]   care;
        logic [LEN_CFG_W-1:0]   length;
    } t_pattern_cfg;

endpackage

// ===== rtl/mbps_cfg_regs.sv =====
module mbps_cfg_regs
    import mbps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    output t_pattern_cfg          o_cfg
);

    t_pattern_cfg r_cfg;
    t_pattern_cfg n_cfg;

    // writes are always taken
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_PATTERN_LOW:  n_cfg.pattern[63:0]   = i_cfg_data;
                CFG_PATTERN_HIGH: n_cfg.pattern[127:64] = i_cfg_data;
                CFG_CARE_MASK:    n_cfg.care            = i_cfg_data[PAT_BYTES-1:0];
                CFG_PATTERN_LEN:  n_cfg.length          = i_cfg_data[LEN_CFG_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern <= '0;
            r_cfg.care    <= '0;
            r_cfg.length  <= LEN_CFG_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== rtl/mbps_window_match.sv =====
module mbps_window_match
    import mbps_pkg::*;
#(
    parameter  int MAX_BYTES = MAX_PATTERN_BYTES_DEF,
    localparam int LEN_W     = $clog2(MAX_BYTES + 1),
    localparam int IDX_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1
) (
    input  t_pattern_cfg                i_cfg,
    input  logic [MAX_BYTES-1:0][7:0]   i_window,
    output logic [LEN_W-1:0]            o_len,
    output logic                        o_match
);

    logic [MAX_BYTES-1:0] hit;

    // zero length acts as one, overlong length is cut to the window depth
    always_comb begin
        if (i_cfg.length == '0) begin
            o_len = LEN_W'(1);
        end else if (32'(i_cfg.length) > 32'(MAX_BYTES)) begin
            o_len = LEN_W'(MAX_BYTES);
        end else begin
            o_len = LEN_W'(i_cfg.length);
        end
    end

    // pattern byte k lines up with window entry len-1-k
    for (genvar k = 0; k < MAX_BYTES; k++) begin : g_byte
        if (k < PAT_BYTES) begin : g_cmp
            logic [LEN_W-1:0] sel;
            assign sel    = o_len - LEN_W'(k) - LEN_W'(1);
            assign hit[k] = (LEN_W'(k) >= o_len) || !i_cfg.care[k]
                            || (i_window[sel[IDX_W-1:0]] == i_cfg.pattern[8*k +: 8]);
        end else begin : g_wild
            assign hit[k] = 1'b1;
        end
    end

    assign o_match = &hit;

endmodule

// ===== rtl/masked_byte_pattern_search_core.sv =====
// masked byte pattern search
//
// the image streams in one byte per transfer on the input channel
// (i_in_valid / o_in_stall), with i_in_last_byte on its final byte. a pattern
// of up to 16 bytes with a per-byte care mask is compared against the newest
// bytes; the start offset of the first match is given once per image on the
// output channel (o_out_valid / i_out_stall). an image that ends without a
// match gives one transfer with found low and offset zero.
// pattern, care mask and length are written through the cfg port
// (i_cfg_valid / o_cfg_ready, always ready); the user must write them while
// the block is idle, which the block itself does not enforce. throughput is
// one byte per cycle unless a held result stalls; window shift and parallel
// compare sit between scan state and result regs; a result shows next cycle.
// when the receiver stalls with a result held, o_in_stall rises and the
// result stays put; input is taken again in the cycle the result leaves.
// reset clears cfg registers, window, byte counter and result valid, not the
// result payload; after the last byte the scan state clears for the next image.
module masked_byte_pattern_search_core
    import mbps_pkg::*;
#(
    parameter  int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
    localparam int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // image byte channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_in_byte_value,
    input  logic                  i_in_last_byte,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_out_found,
    output logic [OFFSET_W-1:0]   o_out_match_offset,
    // register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_pattern_cfg cfg;

    // scan state
    logic [MAX_PATTERN_BYTES-1:0][7:0] r_window;
    logic [MAX_PATTERN_BYTES-1:0][7:0] n_window;
    logic [OFFSET_W-1:0]               r_count;
    logic [OFFSET_W-1:0]               n_count;
    logic                              r_done;
    logic                              n_done;

    // result register
    logic                r_out_valid;
    logic                n_out_valid;
    logic                r_found;
    logic                n_found;
    logic [OFFSET_W-1:0] r_offset;
    logic [OFFSET_W-1:0] n_offset;

    logic [MAX_PATTERN_BYTES-1:0][7:0] win_shift;
    logic [LEN_W-1:0]                  len;
    logic                              win_match;
    logic                              in_take;
    logic                              out_take;
    logic                              can_end;
    logic                              long_enough;
    logic                              hit;
    logic [OFFSET_W-1:0]               count_inc;

    mbps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    // window as it stands once the new byte is in, entry 0 newest
    always_comb begin
        win_shift[0] = i_in_byte_value;
        for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
            win_shift[j] = r_window[j-1];
        end
    end

    mbps_window_match #(
        .MAX_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .i_cfg    (cfg),
        .i_window (win_shift),
        .o_len    (len),
        .o_match  (win_match)
    );

    // a held result blocks new bytes only while the receiver stalls
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_take   = r_out_valid && !i_out_stall;

    // counter saturates; a byte arriving at the limit cannot end a match
    assign can_end     = ~&r_count;
    assign count_inc   = r_count + OFFSET_W'(1);
    assign long_enough = ({1'b0, r_count} + (OFFSET_W+1)'(1)) >= (OFFSET_W+1)'(len);
    assign hit         = !r_done && can_end && long_enough && win_match;

    always_comb begin
        n_window    = r_window;
        n_count     = r_count;
        n_done      = r_done;
        n_out_valid = r_out_valid;
        n_found     = r_found;
        n_offset    = r_offset;
        if (out_take) begin
            n_out_valid = 1'b0;
        end
        if (in_take) begin
            n_window = win_shift;
            if (can_end) begin
                n_count = count_inc;
            end
            if (hit) begin
                n_done      = 1'b1;
                n_out_valid = 1'b1;
                n_found     = 1'b1;
                n_offset    = count_inc - OFFSET_W'(len);
            end else if (i_in_last_byte && !r_done) begin
                // image ended with nothing found
                n_out_valid = 1'b1;
                n_found     = 1'b0;
                n_offset    = '0;
            end
            if (i_in_last_byte) begin
                n_window = '0;
                n_count  = '0;
                n_done   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_count     <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_window    <= n_window;
            r_count     <= n_count;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_found  <= n_found;
        r_offset <= n_offset;
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_found        = r_found;
    assign o_out_match_offset = r_offset;

endmodule

// ===== rtl/mbps_checker.sv =====
module mbps_checker
    import mbps_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic                o_out_found,
    input logic [OFFSET_W-1:0] o_out_match_offset,
    input logic                o_cfg_ready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_found)
            && $stable(o_out_match_offset))
        else $error("stalled result changed");

    // not found always carries offset zero
    a_nf_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_found |-> o_out_match_offset == '0)
        else $error("not found result with nonzero offset");

    // input only held back by a stalled pending result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // no result straight out of reset, cfg port always open
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_cfg_ready)
        else $error("result or cfg state wrong after reset");

endmodule

bind masked_byte_pattern_search_core mbps_checker u_mbps_checker (.*);
